[rtl/core/rbkt_pkg.sv]
// Types and constants shared by the ramp-biased kinetic tensor block.
`default_nettype none

package rbkt_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned ACC_W      = 64;
   localparam int unsigned TEMP_W     = 63;
   localparam int unsigned FRAC_W     = 17;
   localparam int unsigned N_TERMS    = 6;
   localparam int unsigned TERM_IDX_W = 3;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned REQ_DATA_W = 224;
   localparam int unsigned RSP_DATA_W = 448;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_COORD_AXIS   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_AXIS     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COORD_LO     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPAN     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_V_LO    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_V_SPAN  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_FACTOR  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_CONV  = 4'd7;

   localparam logic [TERM_IDX_W-1:0] TERM_LAST = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FRAC_MUL,
      ST_FRAC,
      ST_RAMP_MUL,
      ST_RAMP,
      ST_PROD_MUL,
      ST_SC_LO,
      ST_SC_HI,
      ST_SC_DONE,
      ST_WRITE,
      ST_TRACE_A,
      ST_TRACE_B,
      ST_KE_LOAD
   } state_type;

   typedef enum logic [1:0] {
      ROLE_ACC,
      ROLE_TEMP,
      ROLE_KE
   } role_type;

   // Tensor terms in order xx, yy, zz, xy, xz, yz.
   function automatic logic [1:0] term_axis_a(input logic [TERM_IDX_W-1:0] k);
      logic [1:0] r;
      case (k)
         3'd0:    r = AXIS_X;
         3'd1:    r = AXIS_Y;
         3'd2:    r = AXIS_Z;
         3'd3:    r = AXIS_X;
         3'd4:    r = AXIS_X;
         3'd5:    r = AXIS_Y;
         default: r = AXIS_X;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] term_axis_b(input logic [TERM_IDX_W-1:0] k);
      logic [1:0] r;
      case (k)
         3'd0:    r = AXIS_X;
         3'd1:    r = AXIS_Y;
         3'd2:    r = AXIS_Z;
         3'd3:    r = AXIS_Y;
         3'd4:    r = AXIS_Z;
         3'd5:    r = AXIS_Z;
         default: r = AXIS_X;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/ramp_biased_kinetic_tensor.sv]
// Top level of the ramp-biased kinetic temperature and tensor block.
`default_nettype none

// Each transaction on the req_ channel is one atom. An atom outside the group uses no
// multiplier; an atom in the group holds req_tready low after its acceptance until it is
// done, because every product goes in turn through a single 32x32 multiplier: ramp
// fraction, ramp velocity, then for each of the six tensor terms a velocity product and
// two partial products of the mass scaling. An atom with tlast set then forms the trace
// and runs the temperature scaling and the six energy scalings on the same multiplier,
// and waits first until any earlier result on rsp_ has been taken. Accumulators clear
// after each result. Configuration writes are always accepted and are meant for idle times.
module ramp_biased_kinetic_tensor (
   input  wire  logic                                clock,
   input  wire  logic                                reset,
   input  wire  logic                                req_tvalid,
   output logic                                      req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, atom_mass
   input  wire  logic [rbkt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // in_group
   input  wire  logic                                req_tuser,
   input  wire  logic                                req_tlast,
   output logic                                      rsp_tvalid,
   input  wire  logic                                rsp_tready,
   // temperature, ke_xx, ke_yy, ke_zz, ke_xy, ke_xz, ke_yz, one zero pad bit
   output logic [rbkt_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   input  wire  logic                                csr_valid,
   output logic                                      csr_ready,
   input  wire  logic [rbkt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  logic [rbkt_pkg::WORD_W-1:0]         csr_data
);
   import rbkt_pkg::*;

   state_type state_ff, state_in;
   role_type  role_ff, role_in;
   logic [TERM_IDX_W-1:0] k_ff, k_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic last_ff, last_in;
   logic neg_ff, neg_in;
   logic sh16_ff, sh16_in;

   logic [1:0]        coord_axis_ff, coord_axis_in;
   logic [1:0]        vel_axis_ff, vel_axis_in;
   logic [WORD_W-1:0] coord_lo_ff, coord_lo_in;
   logic [WORD_W-1:0] inv_span_ff, inv_span_in;
   logic [WORD_W-1:0] ramp_v_lo_ff, ramp_v_lo_in;
   logic [WORD_W-1:0] ramp_v_span_ff, ramp_v_span_in;
   logic [WORD_W-1:0] temp_factor_ff, temp_factor_in;
   logic [WORD_W-1:0] energy_conv_ff, energy_conv_in;

   logic [WORD_W-1:0] vel_ff [3];
   logic [WORD_W-1:0] vel_in [3];
   logic [WORD_W-1:0] mass_ff, mass_in;
   logic [WORD_W:0]   dist_ff, dist_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [WORD_W-1:0] factor_ff, factor_in;
   logic [WORD_W-1:0] hi_ff, hi_in;
   logic [ACC_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]  lo_ff, lo_in;
   logic [ACC_W-1:0]  res_ff, res_in;
   logic [ACC_W-1:0]  sums_ff [N_TERMS];
   logic [ACC_W-1:0]  sums_in [N_TERMS];
   logic [ACC_W-1:0]  ke_ff [N_TERMS];
   logic [ACC_W-1:0]  ke_in [N_TERMS];
   logic [TEMP_W-1:0] temp_ff, temp_in;

   logic [WORD_W-1:0] mul_a, mul_b;
   logic [ACC_W-1:0]  mul_p;

   logic [WORD_W-1:0] pos_sel;
   logic [WORD_W:0]   dist_calc;
   logic              dist_pos;
   logic [FRAC_W-1:0] frac_calc;
   logic [WORD_W-1:0] span_mag;
   logic [WORD_W+1:0] ramp_s;
   logic [WORD_W+2:0] vramp;
   logic [1:0]        va_idx;
   logic [WORD_W+3:0] vel_diff;
   logic [WORD_W-1:0] vel_corr;
   logic [WORD_W-1:0] op_a, op_b, op_a_mag, op_b_mag;
   logic              sat_hi;
   logic [ACC_W:0]    shifted;
   logic [ACC_W-1:0]  limit;
   logic [ACC_W-1:0]  mag_r;
   logic [ACC_W-1:0]  scaled;
   logic [ACC_W-1:0]  acc_sum;
   logic [ACC_W-1:0]  trace_ab, trace_all;
   logic [ACC_W-1:0]  sum_sel, sum_mag;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      logic [ACC_W-1:0] r;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = s[ACC_W-1:0];
      end
      return r;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, ke_ff[5], ke_ff[4], ke_ff[3], ke_ff[2], ke_ff[1], ke_ff[0],
                        temp_ff};

   assign mul_p = {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};

   always_comb begin
      case (coord_axis_ff)
         AXIS_X:  pos_sel = req_tdata[31:0];
         AXIS_Y:  pos_sel = req_tdata[63:32];
         default: pos_sel = req_tdata[95:64];
      endcase
   end

   assign dist_calc = {pos_sel[WORD_W-1], pos_sel} - {coord_lo_ff[WORD_W-1], coord_lo_ff};
   assign dist_pos  = !dist_ff[WORD_W] && (dist_ff != '0);
   assign frac_calc = !dist_pos ? '0 :
                      (prod_ff[63:16] > {31'd0, FRAC_ONE}) ? FRAC_ONE : prod_ff[32:16];

   assign span_mag = ramp_v_span_ff[WORD_W-1] ? (~ramp_v_span_ff + 1'b1) : ramp_v_span_ff;
   assign ramp_s   = ramp_v_span_ff[WORD_W-1] ? (~{1'b0, prod_ff[48:16]} + 1'b1)
                                              : {1'b0, prod_ff[48:16]};
   assign vramp    = {{3{ramp_v_lo_ff[WORD_W-1]}}, ramp_v_lo_ff} + {ramp_s[WORD_W+1], ramp_s};
   assign va_idx   = (vel_axis_ff == AXIS_X) ? AXIS_X :
                     (vel_axis_ff == AXIS_Y) ? AXIS_Y : AXIS_Z;
   assign vel_diff = {{4{vel_ff[va_idx][WORD_W-1]}}, vel_ff[va_idx]}
                   - {vramp[WORD_W+2], vramp};

   always_comb begin
      if (vel_diff[WORD_W+3] && (vel_diff[WORD_W+2:WORD_W-1] != 4'hF)) begin
         vel_corr = {1'b1, {(WORD_W-1){1'b0}}};
      end else if (!vel_diff[WORD_W+3] && (vel_diff[WORD_W+2:WORD_W-1] != 4'h0)) begin
         vel_corr = {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
         vel_corr = vel_diff[WORD_W-1:0];
      end
   end

   assign op_a     = vel_ff[term_axis_a(k_ff)];
   assign op_b     = vel_ff[term_axis_b(k_ff)];
   assign op_a_mag = op_a[WORD_W-1] ? (~op_a + 1'b1) : op_a;
   assign op_b_mag = op_b[WORD_W-1] ? (~op_b + 1'b1) : op_b;

   // Recombines the two partial products into (mag * factor) >> 16 or >> 24, saturated.
   assign sat_hi  = sh16_ff ? (prod_ff[63:47] != '0) : (prod_ff[63:55] != '0);
   assign shifted = sh16_ff ? ({prod_ff[48:0], 16'd0} + {17'd0, lo_ff[63:16]})
                            : ({prod_ff[56:0], 8'd0} + {25'd0, lo_ff[63:24]});
   assign limit   = neg_ff ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
   assign mag_r   = (sat_hi || (shifted > {1'b0, limit})) ? limit : shifted[ACC_W-1:0];
   assign scaled  = neg_ff ? (~mag_r + 1'b1) : mag_r;

   assign acc_sum   = sat_add(sums_ff[k_ff], res_ff);
   assign trace_ab  = sat_add(sums_ff[0], sums_ff[1]);
   assign trace_all = sat_add(prod_ff, sums_ff[2]);
   assign sum_sel   = sums_ff[k_ff];
   assign sum_mag   = sum_sel[ACC_W-1] ? (~sum_sel + 1'b1) : sum_sel;

   always_comb begin
      state_in       = state_ff;
      role_in        = role_ff;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      last_in        = last_ff;
      neg_in         = neg_ff;
      sh16_in        = sh16_ff;
      coord_axis_in  = coord_axis_ff;
      vel_axis_in    = vel_axis_ff;
      coord_lo_in    = coord_lo_ff;
      inv_span_in    = inv_span_ff;
      ramp_v_lo_in   = ramp_v_lo_ff;
      ramp_v_span_in = ramp_v_span_ff;
      temp_factor_in = temp_factor_ff;
      energy_conv_in = energy_conv_ff;
      vel_in         = vel_ff;
      mass_in        = mass_ff;
      dist_in        = dist_ff;
      frac_in        = frac_ff;
      factor_in      = factor_ff;
      hi_in          = hi_ff;
      lo_in          = lo_ff;
      res_in         = res_ff;
      sums_in        = sums_ff;
      ke_in          = ke_ff;
      temp_in        = temp_ff;
      mul_a          = '0;
      mul_b          = '0;
      prod_in        = mul_p;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_COORD_AXIS:  coord_axis_in  = csr_data[1:0];
            CSR_VEL_AXIS:    vel_axis_in    = csr_data[1:0];
            CSR_COORD_LO:    coord_lo_in    = csr_data;
            CSR_INV_SPAN:    inv_span_in    = csr_data;
            CSR_RAMP_V_LO:   ramp_v_lo_in   = csr_data;
            CSR_RAMP_V_SPAN: ramp_v_span_in = csr_data;
            CSR_TEMP_FACTOR: temp_factor_in = csr_data;
            CSR_ENERGY_CONV: energy_conv_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               vel_in[0] = req_tdata[127:96];
               vel_in[1] = req_tdata[159:128];
               vel_in[2] = req_tdata[191:160];
               mass_in   = req_tdata[223:192];
               dist_in   = dist_calc;
               last_in   = req_tlast;
               if (req_tuser) begin
                  state_in = ST_FRAC_MUL;
               end else if (req_tlast) begin
                  state_in = ST_TRACE_A;
               end
            end
         end
         ST_FRAC_MUL: begin
            mul_a    = dist_ff[WORD_W-1:0];
            mul_b    = inv_span_ff;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            frac_in  = frac_calc;
            state_in = ST_RAMP_MUL;
         end
         ST_RAMP_MUL: begin
            mul_a    = span_mag;
            mul_b    = {{(WORD_W-FRAC_W){1'b0}}, frac_ff};
            state_in = ST_RAMP;
         end
         ST_RAMP: begin
            vel_in[va_idx] = vel_corr;
            k_in           = '0;
            state_in       = ST_PROD_MUL;
         end
         ST_PROD_MUL: begin
            mul_a     = op_a_mag;
            mul_b     = op_b_mag;
            neg_in    = op_a[WORD_W-1] ^ op_b[WORD_W-1];
            factor_in = mass_ff;
            sh16_in   = 1'b1;
            role_in   = ROLE_ACC;
            state_in  = ST_SC_LO;
         end
         ST_SC_LO: begin
            mul_a    = prod_ff[WORD_W-1:0];
            mul_b    = factor_ff;
            hi_in    = prod_ff[ACC_W-1:WORD_W];
            state_in = ST_SC_HI;
         end
         ST_SC_HI: begin
            mul_a    = hi_ff;
            mul_b    = factor_ff;
            lo_in    = prod_ff;
            state_in = ST_SC_DONE;
         end
         ST_SC_DONE: begin
            res_in   = scaled;
            prod_in  = prod_ff;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            unique case (role_ff)
               ROLE_ACC: begin
                  sums_in[k_ff] = acc_sum;
                  if (k_ff == TERM_LAST) begin
                     state_in = last_ff ? ST_TRACE_A : ST_IDLE;
                  end else begin
                     k_in     = k_ff + 1'b1;
                     state_in = ST_PROD_MUL;
                  end
               end
               ROLE_TEMP: begin
                  temp_in  = res_ff[TEMP_W-1:0];
                  k_in     = '0;
                  state_in = ST_KE_LOAD;
               end
               default: begin
                  ke_in[k_ff] = res_ff;
                  if (k_ff == TERM_LAST) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     k_in     = k_ff + 1'b1;
                     state_in = ST_KE_LOAD;
                  end
               end
            endcase
         end
         ST_TRACE_A: begin
            prod_in = trace_ab;
            if (!rsp_valid_ff) begin
               state_in = ST_TRACE_B;
            end
         end
         ST_TRACE_B: begin
            prod_in   = trace_all[ACC_W-1] ? '0 : trace_all;
            neg_in    = 1'b0;
            factor_in = temp_factor_ff;
            sh16_in   = 1'b0;
            role_in   = ROLE_TEMP;
            state_in  = ST_SC_LO;
         end
         ST_KE_LOAD: begin
            prod_in       = sum_mag;
            neg_in        = sum_sel[ACC_W-1];
            factor_in     = energy_conv_ff;
            sh16_in       = 1'b0;
            role_in       = ROLE_KE;
            sums_in[k_ff] = '0;
            state_in      = ST_SC_LO;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         role_ff        <= ROLE_ACC;
         k_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
         last_ff        <= 1'b0;
         coord_axis_ff  <= AXIS_X;
         vel_axis_ff    <= AXIS_X;
         coord_lo_ff    <= '0;
         inv_span_ff    <= 32'h0001_0000;
         ramp_v_lo_ff   <= '0;
         ramp_v_span_ff <= '0;
         temp_factor_ff <= 32'h0100_0000;
         energy_conv_ff <= 32'h0100_0000;
         for (int i = 0; i < N_TERMS; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         role_ff        <= role_in;
         k_ff           <= k_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_ff        <= last_in;
         coord_axis_ff  <= coord_axis_in;
         vel_axis_ff    <= vel_axis_in;
         coord_lo_ff    <= coord_lo_in;
         inv_span_ff    <= inv_span_in;
         ramp_v_lo_ff   <= ramp_v_lo_in;
         ramp_v_span_ff <= ramp_v_span_in;
         temp_factor_ff <= temp_factor_in;
         energy_conv_ff <= energy_conv_in;
         sums_ff        <= sums_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      sh16_ff   <= sh16_in;
      vel_ff    <= vel_in;
      mass_ff   <= mass_in;
      dist_ff   <= dist_in;
      frac_ff   <= frac_in;
      factor_ff <= factor_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      ke_ff     <= ke_in;
      temp_ff   <= temp_in;
   end

   // A pending result is never overwritten by the next one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && role_ff != ROLE_ACC) |-> !rsp_valid_ff)
      else $error("result register written while a transaction is pending");

   // The accumulators are cleared when a result is presented.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (sums_ff[0] == '0 && sums_ff[1] == '0 && sums_ff[2] == '0 &&
                               sums_ff[3] == '0 && sums_ff[4] == '0 && sums_ff[5] == '0))
      else $error("accumulators not cleared after result");

   // The ramp fraction stays within 0 to 1.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RAMP_MUL) |-> (frac_ff <= FRAC_ONE))
      else $error("ramp fraction out of range");

   // The term counter never passes the last tensor term.
   assert property (@(posedge clock) disable iff (reset)
      k_ff <= TERM_LAST)
      else $error("term counter out of range");

endmodule

`default_nettype wire

[bench/ramp_biased_kinetic_tensor_checker.sv]
// Checker that predicts the temperature and kinetic tensor of each atom set and compares results.
module ramp_biased_kinetic_tensor_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [rbkt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              req_tuser,
   input  wire logic                              req_tlast,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [rbkt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [rbkt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rbkt_pkg::WORD_W-1:0]       csr_data,
   output int                                     failures,
   output int                                     pending_sets,
   output int                                     sets_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import rbkt_pkg::*;

   typedef struct packed {
      logic [TEMP_W-1:0]                  temperature;
      logic [N_TERMS-1:0][ACC_W-1:0]      ke;
   } tensor_set_type;

   logic [1:0] term_first  [N_TERMS] = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_X, AXIS_X, AXIS_Y};
   logic [1:0] term_second [N_TERMS] = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_Y, AXIS_Z, AXIS_Z};
   string      term_name   [N_TERMS] = '{"ke_xx", "ke_yy", "ke_zz", "ke_xy", "ke_xz", "ke_yz"};

   logic [1:0]               ramp_axis_sel;
   logic [1:0]               vel_axis_sel;
   logic signed [WORD_W-1:0] ramp_origin;
   logic signed [WORD_W-1:0] ramp_v_start;
   logic signed [WORD_W-1:0] ramp_v_delta;
   logic [WORD_W-1:0]        inv_span;
   logic [WORD_W-1:0]        temp_gain;
   logic [WORD_W-1:0]        energy_gain;
   longint                   tensor_acc [N_TERMS];
   tensor_set_type           expected_sets [$];
   tensor_set_type           got;
   tensor_set_type           want;
   int                       n;

   // Exact a * b >> sh, truncated toward zero and saturated to 64 signed bits.
   function automatic longint scaled_product(input longint a, input logic [WORD_W-1:0] b,
                                             input int unsigned sh);
      logic [63:0] mag;
      logic [96:0] full;
      logic [96:0] cap;
      mag  = (a < 0) ? -a : a;
      full = ({33'd0, mag} * {65'd0, b}) >> sh;
      cap  = (a < 0) ? (97'd1 << 63) : ((97'd1 << 63) - 97'd1);
      if (full > cap) full = cap;
      return (a < 0) ? -longint'(full[63:0]) : longint'(full[63:0]);
   endfunction

   function automatic longint add_sat(input longint a, input longint b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   function automatic void fold_atom(input logic [REQ_DATA_W-1:0] d);
      logic signed [WORD_W-1:0] pos [3];
      logic signed [WORD_W-1:0] vel [3];
      logic [WORD_W-1:0]        mass;
      logic [1:0]               ca;
      logic [1:0]               va;
      longint                   pos_offset;
      longint                   vramp;
      longint                   corr;
      longint                   prod;
      logic [63:0]              frac;
      int                       k;
      for (k = 0; k < 3; k++) begin
         pos[k] = d[WORD_W*k +: WORD_W];
         vel[k] = d[WORD_W*(3+k) +: WORD_W];
      end
      mass = d[WORD_W*6 +: WORD_W];
      ca   = (ramp_axis_sel > AXIS_Z) ? AXIS_Z : ramp_axis_sel;
      va   = (vel_axis_sel > AXIS_Z) ? AXIS_Z : vel_axis_sel;
      pos_offset = longint'(pos[ca]) - longint'(ramp_origin);
      frac = 64'd0;
      if (pos_offset > 0) begin
         frac = (64'(pos_offset) * {32'd0, inv_span}) >> 16;
         if (frac > 64'(FRAC_ONE)) frac = 64'(FRAC_ONE);
      end
      vramp = longint'(ramp_v_start)
            + scaled_product(longint'(ramp_v_delta), frac[WORD_W-1:0], 16);
      corr = longint'(vel[va]) - vramp;
      if (corr > 64'sd2147483647) corr = 64'sd2147483647;
      if (corr < -64'sd2147483648) corr = -64'sd2147483648;
      vel[va] = corr[WORD_W-1:0];
      for (k = 0; k < N_TERMS; k++) begin
         prod = longint'(vel[term_first[k]]) * longint'(vel[term_second[k]]);
         tensor_acc[k] = add_sat(tensor_acc[k], scaled_product(prod, mass, 16));
      end
   endfunction

   function automatic tensor_set_type close_set();
      tensor_set_type r;
      longint         trace;
      longint         temp;
      int             k;
      trace = add_sat(add_sat(tensor_acc[0], tensor_acc[1]), tensor_acc[2]);
      if (trace < 0) trace = 0;
      temp = scaled_product(trace, temp_gain, 24);
      if (temp < 0) temp = 0;
      r.temperature = temp[TEMP_W-1:0];
      for (k = 0; k < N_TERMS; k++) begin
         r.ke[k]       = scaled_product(tensor_acc[k], energy_gain, 24);
         tensor_acc[k] = 0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ramp_axis_sel = AXIS_X;
         vel_axis_sel  = AXIS_X;
         ramp_origin   = '0;
         inv_span      = 32'h0001_0000;
         ramp_v_start  = '0;
         ramp_v_delta  = '0;
         temp_gain     = 32'h0100_0000;
         energy_gain   = 32'h0100_0000;
         for (n = 0; n < N_TERMS; n++) tensor_acc[n] = 0;
         expected_sets.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.temperature = rsp_tdata[TEMP_W-1:0];
            for (n = 0; n < N_TERMS; n++) got.ke[n] = rsp_tdata[TEMP_W + ACC_W*n +: ACC_W];
            if (expected_sets.size() == 0) begin
               failures++;
               $error("response transaction with no atom set pending");
            end else begin
               want = expected_sets.pop_front();
               sets_checked++;
               if (got.temperature !== want.temperature) begin
                  failures++;
                  $error("temperature mismatch: expected %h, got %h",
                         want.temperature, got.temperature);
               end
               for (n = 0; n < N_TERMS; n++) begin
                  if (got.ke[n] !== want.ke[n]) begin
                     failures++;
                     $error("%s mismatch: expected %h, got %h", term_name[n], want.ke[n],
                            got.ke[n]);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COORD_AXIS:  ramp_axis_sel = csr_data[1:0];
               CSR_VEL_AXIS:    vel_axis_sel  = csr_data[1:0];
               CSR_COORD_LO:    ramp_origin   = csr_data;
               CSR_INV_SPAN:    inv_span      = csr_data;
               CSR_RAMP_V_LO:   ramp_v_start  = csr_data;
               CSR_RAMP_V_SPAN: ramp_v_delta  = csr_data;
               CSR_TEMP_FACTOR: temp_gain     = csr_data;
               CSR_ENERGY_CONV: energy_gain   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) fold_atom(req_tdata);
            if (req_tlast) expected_sets.push_back(close_set());
         end
      end
      pending_sets = expected_sets.size();
   end

endmodule

[bench/ramp_biased_kinetic_tensor_tb.sv]
// Testbench top that drives atom sets and register settings into the kinetic tensor block.
module ramp_biased_kinetic_tensor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rbkt_pkg::*;

   localparam logic [WORD_W-1:0] Q_ONE    = 32'h0001_0000;
   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [1:0]        AXIS_SPARE = 2'd3;
   localparam int                Q_INT = 65536;
   localparam int                PHASES = 9;
   localparam int                ATOMS_PER_PHASE = 185;

   typedef enum logic [1:0] {HOLD_NONE, HOLD_COIN, HOLD_SPARSE, HOLD_LONG} hold_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [WORD_W-1:0]     csr_data = '0;

   int                       failures;
   int                       pending_sets;
   int                       sets_checked;
   int                       atoms_sent = 0;
   int                       useful_atoms = 0;
   int                       settings_used = 1;
   int                       burst_left = 0;
   int                       hold_tick = 0;
   hold_mode_type            hold_mode = HOLD_NONE;
   logic [WORD_W-1:0]        setting [int'(CSR_ENERGY_CONV) + 1];
   logic [WORD_W-1:0]        ramp_origin_now = '0;

   ramp_biased_kinetic_tensor DUT (.*);

   ramp_biased_kinetic_tensor_checker checker_i (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      hold_tick++;
      if (hold_tick % 300 == 0) hold_mode = hold_mode_type'($urandom_range(0, 3));
      case (hold_mode)
         HOLD_NONE:   rsp_tready = 1'b1;
         HOLD_COIN:   rsp_tready = 1'($urandom_range(0, 1));
         HOLD_SPARSE: rsp_tready = ($urandom_range(0, 7) == 0);
         default:     rsp_tready = (hold_tick % 64) < 8;
      endcase
   end

   function automatic logic [REQ_DATA_W-1:0] pack_atom(
      input logic [WORD_W-1:0] px, py, pz, vx, vy, vz, m);
      return {m, vz, vy, vx, pz, py, px};
   endfunction

   function automatic logic [WORD_W-1:0] corner_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return WORD_MAX;
         4:       return WORD_MIN;
         default: return Q_ONE;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] spread_word(input logic [WORD_W-1:0] center,
                                                     input int below, input int above);
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return corner_word();
         default: return center - below + $urandom_range(0, below + above);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_mass();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return '0;
         default: return $urandom_range(0, 4 * Q_INT);
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_atom(input logic [REQ_DATA_W-1:0] d, input logic grp,
                            input logic closes);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tdata  = d;
      req_tuser  = grp;
      req_tlast  = closes;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      atoms_sent++;
   endtask

   task automatic wait_idle();
      int waited;
      waited = 0;
      req_tvalid = 1'b0;
      while (pending_sets != 0 && waited < 50000) begin
         @(negedge clock);
         waited++;
      end
      repeat (90) @(negedge clock);
   endtask

   task automatic program_settings();
      write_reg(CSR_COORD_AXIS, setting[CSR_COORD_AXIS]);
      write_reg(CSR_VEL_AXIS, setting[CSR_VEL_AXIS]);
      write_reg(CSR_COORD_LO, setting[CSR_COORD_LO]);
      write_reg(CSR_INV_SPAN, setting[CSR_INV_SPAN]);
      write_reg(CSR_RAMP_V_LO, setting[CSR_RAMP_V_LO]);
      write_reg(CSR_RAMP_V_SPAN, setting[CSR_RAMP_V_SPAN]);
      write_reg(CSR_TEMP_FACTOR, setting[CSR_TEMP_FACTOR]);
      write_reg(CSR_ENERGY_CONV, setting[CSR_ENERGY_CONV]);
      // Writes to indexes past the last register must leave every setting alone.
      write_reg(CSR_ENERGY_CONV + CSR_IDX_W'(1 + $urandom_range(0, 7)), $urandom());
      ramp_origin_now = setting[CSR_COORD_LO];
      settings_used++;
   endtask

   task automatic choose_settings(input int p);
      case (p)
         1: begin
            setting[CSR_COORD_AXIS]  = 32'(AXIS_SPARE);
            setting[CSR_VEL_AXIS]    = 32'(AXIS_SPARE);
            setting[CSR_COORD_LO]    = WORD_MIN;
            setting[CSR_INV_SPAN]    = '1;
            setting[CSR_RAMP_V_LO]   = WORD_MAX;
            setting[CSR_RAMP_V_SPAN] = WORD_MIN;
            setting[CSR_TEMP_FACTOR] = '1;
            setting[CSR_ENERGY_CONV] = '1;
         end
         2: begin
            setting[CSR_COORD_AXIS]  = 32'(AXIS_X);
            setting[CSR_VEL_AXIS]    = 32'(AXIS_X);
            setting[CSR_COORD_LO]    = WORD_MAX;
            setting[CSR_INV_SPAN]    = '0;
            setting[CSR_RAMP_V_LO]   = WORD_MIN;
            setting[CSR_RAMP_V_SPAN] = WORD_MAX;
            setting[CSR_TEMP_FACTOR] = '0;
            setting[CSR_ENERGY_CONV] = 32'd1;
         end
         default: begin
            setting[CSR_COORD_AXIS]  = $urandom_range(0, 3);
            setting[CSR_VEL_AXIS]    = $urandom_range(0, 3);
            setting[CSR_COORD_LO]    = $urandom_range(0, 40 * Q_INT) - 20 * Q_INT;
            setting[CSR_INV_SPAN]    = $urandom_range(32'h800, 32'h2_0000);
            setting[CSR_RAMP_V_LO]   = $urandom_range(0, 8 * Q_INT) - 4 * Q_INT;
            setting[CSR_RAMP_V_SPAN] = $urandom_range(0, 16 * Q_INT) - 8 * Q_INT;
            if (p % 3 == 0) begin
               setting[CSR_TEMP_FACTOR] = $urandom();
               setting[CSR_ENERGY_CONV] = $urandom();
            end else begin
               setting[CSR_TEMP_FACTOR] = $urandom_range(0, 32'h400_0000);
               setting[CSR_ENERGY_CONV] = $urandom_range(32'h10_0000, 32'h400_0000);
            end
         end
      endcase
   endtask

   task automatic send_random_set();
      int   len;
      int   k;
      logic grp;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
         grp = ($urandom_range(0, 99) < 85);
         send_atom(pack_atom(spread_word(ramp_origin_now, 4 * Q_INT, 40 * Q_INT),
                             spread_word(ramp_origin_now, 4 * Q_INT, 40 * Q_INT),
                             spread_word(ramp_origin_now, 4 * Q_INT, 40 * Q_INT),
                             spread_word('0, 8 * Q_INT, 8 * Q_INT),
                             spread_word('0, 8 * Q_INT, 8 * Q_INT),
                             spread_word('0, 8 * Q_INT, 8 * Q_INT),
                             random_mass()), grp, k == len - 1);
         if (grp || k == len - 1) useful_atoms++;
      end
   endtask

   task automatic directed_checks();
      send_atom(pack_atom('0, '0, '0, '0, '0, '0, '0), 1'b1, 1'b1);
      send_atom(pack_atom(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX, '1),
                1'b1, 1'b0);
      send_atom(pack_atom(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '1),
                1'b1, 1'b1);
      send_atom(pack_atom('0, '0, '0, Q_ONE, 32'hFFFE_0000, 32'h0003_0000, Q_ONE), 1'b1, 1'b0);
      send_atom(pack_atom('1, '1, '1, WORD_MAX, WORD_MAX, WORD_MAX, '1), 1'b0, 1'b0);
      // The set closes on an atom outside the group, then on an empty set.
      send_atom(pack_atom(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE), 1'b0, 1'b1);
      send_atom(pack_atom('0, '0, '0, 32'h5555_AAAA, '0, '0, Q_ONE), 1'b0, 1'b1);
      send_atom(pack_atom('0, '0, '0, WORD_MAX, WORD_MAX, WORD_MAX, '0), 1'b1, 1'b1);
      wait_idle();
      // Axis code three selects z, and the corrected velocity saturates both ways.
      write_reg(CSR_COORD_AXIS, 32'(AXIS_SPARE));
      write_reg(CSR_VEL_AXIS, 32'(AXIS_SPARE));
      write_reg(CSR_RAMP_V_LO, WORD_MAX);
      send_atom(pack_atom('0, '0, '0, '0, '0, WORD_MIN, Q_ONE), 1'b1, 1'b1);
      wait_idle();
      write_reg(CSR_RAMP_V_LO, WORD_MIN);
      send_atom(pack_atom('0, '0, '0, '0, '0, WORD_MAX, Q_ONE), 1'b1, 1'b1);
      wait_idle();
      write_reg(CSR_INV_SPAN, '0);
      write_reg(CSR_RAMP_V_LO, '0);
      write_reg(CSR_RAMP_V_SPAN, 32'h000A_0000);
      send_atom(pack_atom('0, '0, WORD_MAX, Q_ONE, Q_ONE, Q_ONE, Q_ONE), 1'b1, 1'b1);
      wait_idle();
      write_reg(CSR_INV_SPAN, '1);
      write_reg(CSR_COORD_LO, WORD_MIN);
      write_reg(CSR_RAMP_V_SPAN, WORD_MIN);
      send_atom(pack_atom('0, '0, WORD_MAX, '0, '0, '0, Q_ONE), 1'b1, 1'b0);
      send_atom(pack_atom('0, '0, WORD_MIN, Q_ONE, '0, 32'hFFFF_0000, Q_ONE), 1'b1, 1'b1);
      settings_used += 4;
   endtask

   initial begin
      int p;
      int start;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      directed_checks();
      for (p = 1; p <= PHASES; p++) begin
         wait_idle();
         choose_settings(p);
         program_settings();
         start = useful_atoms;
         while (useful_atoms - start < ATOMS_PER_PHASE) send_random_set();
      end
      wait_idle();
      $display("Sent %0d atoms under %0d register settings; %0d tensor results compared.",
               atoms_sent, settings_used, sets_checked);
      if (failures == 0 && pending_sets == 0) begin
         $display("ramp_biased_kinetic_tensor regression: pass");
      end else begin
         $display("ramp_biased_kinetic_tensor regression: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("ramp_biased_kinetic_tensor regression: fail");
      $finish;
   end

endmodule

[sim.f]
rtl/core/rbkt_pkg.sv
rtl/core/ramp_biased_kinetic_tensor.sv
bench/ramp_biased_kinetic_tensor_checker.sv
bench/ramp_biased_kinetic_tensor_tb.sv
